// ===== rtl/rfed_pkg.sv =====
// Package for the radar frame event decoder: frame constants, protocol codes
// and the record types passed between the parser and the classifier.
// No dependencies.
package rfed_pkg;

    localparam int unsigned MAX_FRAME_LEN = 128;
    localparam int unsigned LEN_W         = 8;
    localparam int unsigned CAPT_DEPTH    = 5;

    localparam logic [7:0] HDR_A  = 8'h53;
    localparam logic [7:0] HDR_B  = 8'h59;
    localparam logic [7:0] TAIL_A = 8'h54;
    localparam logic [7:0] TAIL_B = 8'h43;

    localparam logic [LEN_W-1:0] MIN_CLASSIFY_LEN = 8'd10;
    localparam logic [LEN_W-1:0] FIRST_CAPT_POS   = 8'd2;
    localparam logic [LEN_W-1:0] LAST_CAPT_POS    = 8'd6;
    localparam logic [LEN_W-1:0] MAX_LEN          = LEN_W'(MAX_FRAME_LEN);

    // Frame codes in bytes 2..6.
    localparam logic [7:0] FALL_CTRL     = 8'h83;
    localparam logic [7:0] FALL_CMD      = 8'h01;
    localparam logic [7:0] FALL_DATA     = 8'h01;
    localparam logic [7:0] MOVE_CTRL     = 8'h80;
    localparam logic [7:0] MOVE_CMD      = 8'h03;
    localparam logic [7:0] MOVE_LEN_HI   = 8'h00;
    localparam logic [7:0] MOVE_LEN_LO   = 8'h01;

    localparam logic [15:0] IDLE_MAX     = 16'hFFFF;
    localparam logic [7:0]  THRESH_RESET = 8'd10;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESH = 1'b1;

    localparam int unsigned OUT_DATA_W = 32;

    // A closed frame: length check and the five captured bytes.
    typedef struct packed {
        logic       long_enough;
        logic [7:0] byte6;
        logic [7:0] byte5;
        logic [7:0] byte4;
        logic [7:0] byte3;
        logic [7:0] byte2;
    } t_frame_rec;

    typedef struct packed {
        logic [15:0] idle_seconds;
        logic        idle_alarm;
        logic [7:0]  movement_level;
        logic        movement_report;
        logic        fall_detected;
    } t_result;

endpackage

// ===== rtl/rfed_parser.sv =====
// Byte-level frame parser: header hunt, byte capture, tail and overrun checks.
// Holds one closed-frame record for the classifier. Depends on rfed_pkg.
module rfed_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    output logic                 o_rec_valid,
    input  logic                 i_rec_ready,
    output rfed_pkg::t_frame_rec o_rec
);

    logic                             r_in_frame, n_in_frame;
    logic [7:0]                       r_prev, n_prev;
    logic [rfed_pkg::LEN_W-1:0]       r_len, n_len;
    logic [7:0]                       r_capt [rfed_pkg::CAPT_DEPTH];
    logic [7:0]                       n_capt [rfed_pkg::CAPT_DEPTH];
    logic                             r_rec_valid, n_rec_valid;
    rfed_pkg::t_frame_rec             r_rec, n_rec;

    logic                             accept;
    logic                             rec_take;
    logic [rfed_pkg::LEN_W-1:0]       len_inc;
    logic [rfed_pkg::LEN_W-1:0]       capt_off;
    logic                             close_now;

    assign rec_take = r_rec_valid && i_rec_ready;
    assign o_ready  = !r_rec_valid || i_rec_ready;
    assign accept   = i_valid && o_ready;
    assign len_inc  = r_len + 1'b1;
    assign capt_off = r_len - rfed_pkg::FIRST_CAPT_POS;
    assign close_now = accept && r_in_frame
                       && r_prev == rfed_pkg::TAIL_A && i_byte == rfed_pkg::TAIL_B;

    always_comb begin
        n_in_frame = r_in_frame;
        n_prev     = r_prev;
        n_len      = r_len;
        n_capt     = r_capt;
        n_rec      = r_rec;
        n_rec_valid = r_rec_valid && !rec_take;
        if (accept) begin
            n_prev = i_byte;
            if (!r_in_frame) begin
                if (r_prev == rfed_pkg::HDR_A && i_byte == rfed_pkg::HDR_B) begin
                    n_in_frame = 1'b1;
                    n_len      = rfed_pkg::FIRST_CAPT_POS;
                    for (int k = 0; k < rfed_pkg::CAPT_DEPTH; k++) begin
                        n_capt[k] = 8'h00;
                    end
                end
            end else begin
                if (r_len >= rfed_pkg::FIRST_CAPT_POS && r_len <= rfed_pkg::LAST_CAPT_POS) begin
                    n_capt[capt_off[2:0]] = i_byte;
                end
                n_len = len_inc;
                if (close_now) begin
                    // Long frames finished capturing long before the tail.
                    n_rec.long_enough = len_inc >= rfed_pkg::MIN_CLASSIFY_LEN;
                    n_rec.byte2 = r_capt[0];
                    n_rec.byte3 = r_capt[1];
                    n_rec.byte4 = r_capt[2];
                    n_rec.byte5 = r_capt[3];
                    n_rec.byte6 = r_capt[4];
                    n_rec_valid = 1'b1;
                    n_in_frame  = 1'b0;
                    n_len       = '0;
                end else if (len_inc >= rfed_pkg::MAX_LEN) begin
                    n_in_frame = 1'b0;
                    n_len      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_prev      <= 8'h00;
            r_len       <= '0;
            r_rec_valid <= 1'b0;
            for (int k = 0; k < rfed_pkg::CAPT_DEPTH; k++) begin
                r_capt[k] <= 8'h00;
            end
        end else begin
            r_in_frame  <= n_in_frame;
            r_prev      <= n_prev;
            r_len       <= n_len;
            r_rec_valid <= n_rec_valid;
            r_capt      <= n_capt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

endmodule

// ===== rtl/rfed_classifier.sv =====
// Frame classifier and idle counter with the result register and the
// configuration registers. Depends on rfed_pkg.
module rfed_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rfed_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rfed_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_rec_valid,
    output logic                                 o_rec_ready,
    input  rfed_pkg::t_frame_rec                 i_rec,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output rfed_pkg::t_result                    o_result
);

    logic [15:0]        r_idle_limit;
    logic [7:0]         r_thresh;
    logic [15:0]        r_idle_count, n_idle_count;
    logic               r_valid, n_valid;
    rfed_pkg::t_result  r_result, n_result;

    logic        take;
    logic        is_fall;
    logic        is_move;
    logic [15:0] count_inc;

    assign o_rec_ready = !r_valid || i_ready;
    assign take        = i_rec_valid && o_rec_ready;

    assign is_fall = i_rec.long_enough && i_rec.byte2 == rfed_pkg::FALL_CTRL
                     && i_rec.byte3 == rfed_pkg::FALL_CMD
                     && i_rec.byte6 == rfed_pkg::FALL_DATA;
    assign is_move = i_rec.long_enough && i_rec.byte2 == rfed_pkg::MOVE_CTRL
                     && i_rec.byte3 == rfed_pkg::MOVE_CMD
                     && i_rec.byte4 == rfed_pkg::MOVE_LEN_HI
                     && i_rec.byte5 == rfed_pkg::MOVE_LEN_LO;
    assign count_inc = (r_idle_count == rfed_pkg::IDLE_MAX) ? r_idle_count
                                                            : r_idle_count + 16'd1;

    always_comb begin
        n_idle_count = r_idle_count;
        n_result     = r_result;
        n_valid      = r_valid && !i_ready;
        if (take) begin
            n_result.fall_detected   = is_fall;
            n_result.movement_report = is_move;
            n_result.movement_level  = is_move ? i_rec.byte6 : 8'h00;
            n_result.idle_alarm      = 1'b0;
            if (is_move) begin
                if (i_rec.byte6 < r_thresh) begin
                    // The limit check follows the increment; a zero limit never fires.
                    if (r_idle_limit != 16'd0 && count_inc >= r_idle_limit) begin
                        n_result.idle_alarm = 1'b1;
                        n_idle_count        = 16'd0;
                    end else begin
                        n_idle_count = count_inc;
                    end
                end else begin
                    n_idle_count = 16'd0;
                end
            end
            n_result.idle_seconds = n_idle_count;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= 16'd0;
            r_thresh     <= rfed_pkg::THRESH_RESET;
            r_idle_count <= 16'd0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rfed_pkg::CFG_IDLE_LIMIT:  r_idle_limit <= i_cfg_data;
                    rfed_pkg::CFG_MOVE_THRESH: r_thresh     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_idle_count <= n_idle_count;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/radar_frame_event_decoder.sv =====
// Top level of the radar frame event decoder: parser followed by classifier.
// Depends on rfed_pkg, rfed_parser and rfed_classifier.
//
// Usage: the slave stream carries one received serial byte per item in
// i_s_tdata[7:0]. The block hunts for the header 0x53 0x59, collects a frame
// until the tail 0x54 0x43, and then emits one result item on the master
// stream for each closed frame; bytes that do not close a frame give no item.
// Frames that reach the maximum length without a tail are dropped.
// Throughput is one byte per cycle while o_s_tready is high. A closed frame
// is held in the closed-frame record register and then passes to the result
// register, which drives o_m_tvalid. When the receiver stalls, the result
// register holds and one more closed-frame record may wait behind it;
// while that record waits, o_s_tready stays low and no byte is taken
// until the result register frees.
// Reset (i_rst_n low, synchronous) clears the parser, the idle counter,
// both result stages, and sets idle_limit to 0 and movement_threshold to 10.
// Configuration writes take effect at once; write only while the block is idle.
module radar_frame_event_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rfed_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rfed_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [7:0] rx_byte
    input  logic [7:0]                           i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [0] fall_detected, [1] movement_report, [9:2] movement_level,
    // [10] idle_alarm, [26:11] idle_seconds, [31:27] zero
    output logic [rfed_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    logic                 rec_valid;
    logic                 rec_ready;
    rfed_pkg::t_frame_rec rec;
    rfed_pkg::t_result    result;

    rfed_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_byte      (i_s_tdata),
        .o_rec_valid (rec_valid),
        .i_rec_ready (rec_ready),
        .o_rec       (rec)
    );

    rfed_classifier u_classifier (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rec_valid (rec_valid),
        .o_rec_ready (rec_ready),
        .i_rec       (rec),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_result    (result)
    );

    assign o_m_tdata = rfed_pkg::OUT_DATA_W'(result);

endmodule

// ===== rtl/rfed_checker.sv =====
// Port-level checks for the radar frame event decoder, bound to the top level.
// Depends on radar_frame_event_decoder.
module rfed_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    property p_hold_on_stall;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata));
    endproperty
    a_hold_on_stall: assert property (p_hold_on_stall)
        else $error("result item changed while stalled");

    property p_empty_after_reset;
        @(posedge i_clk) !i_rst_n |=> !o_m_tvalid;
    endproperty
    a_empty_after_reset: assert property (p_empty_after_reset)
        else $error("result valid right after reset");

    property p_level_needs_move;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[1]) |-> (o_m_tdata[9:2] == 8'h00);
    endproperty
    a_level_needs_move: assert property (p_level_needs_move)
        else $error("movement level set on a non-movement frame");

    property p_alarm_clears;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[10]) |-> (o_m_tdata[1] && o_m_tdata[26:11] == 16'd0);
    endproperty
    a_alarm_clears: assert property (p_alarm_clears)
        else $error("idle alarm without movement frame or counter clear");

    property p_one_kind;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]);
    endproperty
    a_one_kind: assert property (p_one_kind)
        else $error("frame classified as both fall and movement");

endmodule

bind radar_frame_event_decoder rfed_checker u_rfed_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for radar_frame_event_decoder: feeds serial bytes on the
// input stream, predicts each frame report and compares it on the output stream.
// Depends on rfed_pkg and the decoder RTL.
module tb_top;
    import rfed_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SQUEEZE_CYCLES = 400;
    localparam int unsigned FAST_FRAMES = 20;
    localparam int unsigned RANDOM_BYTES = 160;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = 8'h00;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    radar_frame_event_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Bytes waiting to be sent, and reports the decoder owes us.
    logic [7:0]  rx_stream [$];
    t_result     pending_reports [$];
    int unsigned failures = 0;

    // Shadow of the decoder state and its two registers.
    logic        frame_open = 1'b0;
    logic [7:0]  last_rx = 8'h00;
    logic [7:0]  frame_bytes = 8'h00;
    logic [7:0]  frame_head [CAPT_DEPTH];
    logic [15:0] idle_run = 16'h0000;
    logic [15:0] limit_reg = 16'h0000;
    logic [7:0]  thr_reg = THRESH_RESET;

    // Pacing controls shared between the stimulus and the two stream sides.
    bit          fast_phase = 1'b0;
    bit          squeeze_armed = 1'b0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned squeeze_left = 0;
    int unsigned quiet_cycles = 0;

    function automatic void decode_rx_byte(input logic [7:0] b);
        logic [7:0] prev;
        logic       long_enough;
        t_result    r;
        prev = last_rx;
        last_rx = b;
        if (!frame_open) begin
            if (prev == HDR_A && b == HDR_B) begin
                frame_open = 1'b1;
                frame_bytes = FIRST_CAPT_POS;
                foreach (frame_head[i]) frame_head[i] = 8'h00;
            end
            return;
        end
        if (frame_bytes >= FIRST_CAPT_POS && frame_bytes <= LAST_CAPT_POS)
            frame_head[3'(frame_bytes - FIRST_CAPT_POS)] = b;
        frame_bytes = frame_bytes + 8'd1;
        if (prev == TAIL_A && b == TAIL_B) begin
            long_enough = frame_bytes >= MIN_CLASSIFY_LEN;
            r = '0;
            r.fall_detected = long_enough && frame_head[0] == FALL_CTRL &&
                              frame_head[1] == FALL_CMD && frame_head[4] == FALL_DATA;
            r.movement_report = long_enough && frame_head[0] == MOVE_CTRL &&
                                frame_head[1] == MOVE_CMD && frame_head[2] == MOVE_LEN_HI &&
                                frame_head[3] == MOVE_LEN_LO;
            if (r.movement_report) begin
                r.movement_level = frame_head[4];
                if (frame_head[4] < thr_reg) begin
                    if (idle_run != IDLE_MAX) idle_run = idle_run + 16'd1;
                    if (limit_reg != 16'd0 && idle_run >= limit_reg) begin
                        r.idle_alarm = 1'b1;
                        idle_run = 16'h0000;
                    end
                end else begin
                    idle_run = 16'h0000;
                end
            end
            r.idle_seconds = idle_run;
            pending_reports.push_back(r);
            frame_open = 1'b0;
            frame_bytes = 8'h00;
        end else if (frame_bytes >= MAX_LEN) begin
            // Too long without a tail: dropped silently.
            frame_open = 1'b0;
            frame_bytes = 8'h00;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void check_report(input logic [OUT_DATA_W-1:0] word);
        t_result got;
        t_result want;
        got = t_result'(word[$bits(t_result)-1:0]);
        if (pending_reports.size() == 0) begin
            failures++;
            $display("%0t: unexpected report, expected none, actual %h", $time, word);
            return;
        end
        want = pending_reports.pop_front();
        compare_field("fall_detected", 32'(want.fall_detected), 32'(got.fall_detected));
        compare_field("movement_report", 32'(want.movement_report),
                      32'(got.movement_report));
        compare_field("movement_level", 32'(want.movement_level), 32'(got.movement_level));
        compare_field("idle_alarm", 32'(want.idle_alarm), 32'(got.idle_alarm));
        compare_field("idle_seconds", 32'(want.idle_seconds), 32'(got.idle_seconds));
        compare_field("tdata padding", 32'd0, 32'(word[OUT_DATA_W-1:$bits(t_result)]));
    endfunction

    // Input side: one item in flight, a random gap drawn per item.
    always @(posedge i_clk) begin : sender
        logic       nxt_valid;
        logic [7:0] nxt_data;
        nxt_valid = i_s_tvalid;
        nxt_data = i_s_tdata;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                decode_rx_byte(i_s_tdata);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (rx_stream.size() != 0) begin
                    nxt_valid = 1'b1;
                    nxt_data = rx_stream.pop_front();
                    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
                    tx_wait = (fast_phase || tx_calm) ? 0 : $urandom_range(0, 12);
                end
            end
        end
        i_s_tvalid <= nxt_valid;
        i_s_tdata <= nxt_data;
    end

    // Output side: checks each item, then stalls for a random number of cycles.
    always @(posedge i_clk) begin : receiver
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                check_report(o_m_tdata);
                if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
                rx_wait = (fast_phase || rx_calm) ? 0 : $urandom_range(0, 12);
                if (squeeze_armed) begin
                    squeeze_armed = 1'b0;
                    squeeze_left = SQUEEZE_CYCLES;
                end
            end
            if (squeeze_left > 0) begin
                squeeze_left--;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        i_m_tready <= nxt_ready;
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void send_frame(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2, input logic [7:0] c3,
                                       input logic [7:0] c4, input int pad, input bit noisy);
        rx_stream.push_back(HDR_A);
        rx_stream.push_back(HDR_B);
        rx_stream.push_back(c0);
        rx_stream.push_back(c1);
        rx_stream.push_back(c2);
        rx_stream.push_back(c3);
        rx_stream.push_back(c4);
        for (int i = 0; i < pad; i++)
            rx_stream.push_back(noisy ? 8'($urandom_range(0, 255)) : 8'h00);
        rx_stream.push_back(TAIL_A);
        rx_stream.push_back(TAIL_B);
    endfunction

    // Header plus a body with no tail; body bytes counts the final byte too.
    function automatic void send_unclosed(input int body, input logic [7:0] last,
                                          input bit noisy);
        rx_stream.push_back(HDR_A);
        rx_stream.push_back(HDR_B);
        for (int i = 0; i < body - 1; i++)
            rx_stream.push_back(noisy ? 8'($urandom_range(0, 255)) : 8'h00);
        rx_stream.push_back(last);
    endfunction

    function automatic void random_traffic(input int n_bytes);
        int         target;
        int         kind;
        int         n;
        logic [7:0] lvl;
        logic [7:0] c [5];
        target = rx_stream.size() + n_bytes;
        while (rx_stream.size() < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // Lean toward idle levels so the alarm gets reached.
                if (thr_reg != 8'd0 && $urandom_range(0, 1) == 1)
                    lvl = 8'($urandom_range(0, thr_reg - 1));
                else
                    lvl = 8'($urandom_range(0, 255));
                send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, lvl,
                           $urandom_range(0, 6), 1'b1);
            end else if (kind < 55) begin
                lvl = ($urandom_range(0, 3) != 0) ? FALL_DATA : 8'($urandom_range(0, 255));
                send_frame(FALL_CTRL, FALL_CMD, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), lvl, $urandom_range(0, 6), 1'b1);
            end else if (kind < 65) begin
                // A known frame with one byte of its head spoiled.
                if ($urandom_range(0, 1) == 1) begin
                    c[0] = MOVE_CTRL; c[1] = MOVE_CMD; c[2] = MOVE_LEN_HI;
                    c[3] = MOVE_LEN_LO; c[4] = 8'($urandom_range(0, 255));
                end else begin
                    c[0] = FALL_CTRL; c[1] = FALL_CMD; c[2] = 8'($urandom_range(0, 255));
                    c[3] = 8'($urandom_range(0, 255)); c[4] = FALL_DATA;
                end
                c[3'($urandom_range(0, 4))] = 8'($urandom_range(0, 255));
                send_frame(c[0], c[1], c[2], c[3], c[4], $urandom_range(0, 6), 1'b1);
            end else if (kind < 75) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), $urandom_range(0, 6), 1'b1);
            end else if (kind < 87) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    rx_stream.push_back(($urandom_range(0, 3) == 0) ?
                                        HDR_A : 8'($urandom_range(0, 255)));
            end else if (kind < 99) begin
                rx_stream.push_back(HDR_A);
                rx_stream.push_back(HDR_B);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                    rx_stream.push_back(8'($urandom_range(0, 255)));
                rx_stream.push_back(TAIL_A);
                rx_stream.push_back(TAIL_B);
            end else begin
                send_unclosed(MAX_FRAME_LEN - 2, 8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endfunction

    task automatic set_config(input logic [15:0] limit, input logic [7:0] thr);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_IDLE_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_index <= CFG_MOVE_THRESH;
        i_cfg_data <= {8'h00, thr};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = limit;
        thr_reg = thr;
        @(negedge i_clk);
    endtask

    // Wait until every byte is in and every report is out, then let the
    // pipeline settle past a byte that closed nothing.
    task automatic drain();
        do @(negedge i_clk);
        while (rx_stream.size() != 0 || i_s_tvalid || pending_reports.size() != 0);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(16'd2, 8'd10);
        send_frame(FALL_CTRL, FALL_CMD, 8'h00, 8'h00, FALL_DATA, 1, 1'b0);
        send_frame(FALL_CTRL, FALL_CMD, 8'hFF, 8'hFF, 8'hFF, 1, 1'b0);
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'h00, 1, 1'b0);
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'h09, 1, 1'b0);
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'h0A, 1, 1'b0);
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'hFF, 1, 1'b0);
        // Movement codes but only nine bytes long, so never classified.
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'h00, 0, 1'b0);
        // The header's second byte is the first candidate for the tail pair.
        rx_stream.push_back(HDR_A); rx_stream.push_back(HDR_B);
        rx_stream.push_back(TAIL_A); rx_stream.push_back(TAIL_B);
        rx_stream.push_back(HDR_A); rx_stream.push_back(HDR_B);
        rx_stream.push_back(TAIL_B); rx_stream.push_back(TAIL_A);
        rx_stream.push_back(TAIL_B);
        rx_stream.push_back(8'hFF); rx_stream.push_back(8'h00);
        rx_stream.push_back(HDR_A); rx_stream.push_back(8'hAA);
        rx_stream.push_back(8'h55); rx_stream.push_back(HDR_A);
        // Tail lands exactly on the maximum length.
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'h05,
                   MAX_FRAME_LEN - 9, 1'b0);
        send_unclosed(MAX_FRAME_LEN - 2, 8'h00, 1'b0);
        // A dropped frame whose last byte starts the next header.
        send_unclosed(MAX_FRAME_LEN - 2, HDR_A, 1'b0);
        rx_stream.push_back(HDR_B);
        rx_stream.push_back(FALL_CTRL); rx_stream.push_back(FALL_CMD);
        rx_stream.push_back(8'h00); rx_stream.push_back(8'h00);
        rx_stream.push_back(FALL_DATA); rx_stream.push_back(8'h00);
        rx_stream.push_back(TAIL_A); rx_stream.push_back(TAIL_B);
        drain();

        // Alarm off: a run of idle movement frames at full rate.
        set_config(16'd0, 8'd255);
        fast_phase = 1'b1;
        for (int k = 0; k < FAST_FRAMES; k++)
            send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'h00, 1, 1'b0);
        drain();
        fast_phase = 1'b0;

        set_config(16'hFFFF, 8'd1);
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'h00, 1, 1'b0);
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'h00, 1, 1'b0);
        drain();
        set_config(16'hFFFF, 8'd0);
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'h00, 1, 1'b0);
        send_frame(MOVE_CTRL, MOVE_CMD, MOVE_LEN_HI, MOVE_LEN_LO, 8'hFF, 1, 1'b0);
        drain();

        squeeze_armed = 1'b1;
        set_config(16'($urandom_range(1, 5)), 8'($urandom_range(1, 254)));
        random_traffic(RANDOM_BYTES);
        drain();
        set_config(16'd0, 8'd255);
        random_traffic(RANDOM_BYTES);
        drain();
        set_config(16'd1, 8'd0);
        random_traffic(RANDOM_BYTES);
        drain();
        set_config(16'($urandom_range(2, 8)), 8'd128);
        random_traffic(RANDOM_BYTES);
        drain();
        set_config(16'hFFFF, 8'($urandom_range(0, 255)));
        random_traffic(RANDOM_BYTES);
        drain();

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rfed_pkg.sv
rtl/rfed_parser.sv
rtl/rfed_classifier.sv
rtl/radar_frame_event_decoder.sv
rtl/rfed_checker.sv
bench/tb_top.sv
